// File: hdl/rmsd_pkg.sv
`timescale 1ns / 1ps
// shared constants for the incremental rmsd update pipeline
// no dependencies

package rmsd_pkg;
    localparam int CoordWidthDef  = 21;
    localparam int RotFracBitsDef = 18;
    localparam int RotStride      = 20;
    localparam int RmsdWidth      = 24;
    localparam int CountWidth     = 16;
    localparam int CfgIndexWidth  = 8;
    localparam logic [RmsdWidth-1:0] RmsdMax = {RmsdWidth{1'b1}};
    localparam logic [CfgIndexWidth-1:0] CfgUnnormMode = 8'd0;
    localparam logic [CfgIndexWidth-1:0] CfgSiteCount  = 8'd1;
endpackage

// File: hdl/rmsd_div_pipe.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// depends on rmsd_pkg

module rmsd_div_pipe
    import rmsd_pkg::*;
#(
    parameter int MW  = 56,
    parameter int DVW = CountWidth,
    parameter int SW  = 49
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [MW-1:0]  in_num,
    input  logic [SW-1:0]  in_side,
    input  logic [DVW-1:0] divisor,
    output logic           out_valid,
    output logic [MW-1:0]  out_quo,
    output logic [SW-1:0]  out_side
);
    logic           v_reg    [MW];
    logic [MW-1:0]  w_reg    [MW];
    logic [DVW-1:0] r_reg    [MW];
    logic [SW-1:0]  side_reg [MW];

    genvar i;
    generate
        for (i = 0; i < MW; i++) begin : g_stage
            logic           src_v;
            logic [MW-1:0]  src_w;
            logic [DVW-1:0] src_r;
            logic [SW-1:0]  src_s;
            logic [DVW:0]   t;
            logic           ge;
            logic [DVW:0]   diff;
            if (i == 0) begin : g_first
                assign src_v = in_valid;
                assign src_w = in_num;
                assign src_r = '0;
                assign src_s = in_side;
            end else begin : g_next
                assign src_v = v_reg[i-1];
                assign src_w = w_reg[i-1];
                assign src_r = r_reg[i-1];
                assign src_s = side_reg[i-1];
            end
            assign t    = {src_r, src_w[MW-1]};
            assign ge   = t >= {1'b0, divisor};
            assign diff = t - {1'b0, divisor};
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (adv) begin
                    v_reg[i] <= src_v;
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    w_reg[i]    <= {src_w[MW-2:0], ge};
                    r_reg[i]    <= ge ? diff[DVW-1:0] : t[DVW-1:0];
                    side_reg[i] <= src_s;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[MW-1];
    assign out_quo   = w_reg[MW-1];
    assign out_side  = side_reg[MW-1];
endmodule

// File: hdl/rmsd_sqrt_pipe.sv
`timescale 1ns / 1ps
// pipelined integer floor square root, one root bit per stage
// depends on rmsd_pkg

module rmsd_sqrt_pipe
    import rmsd_pkg::*;
#(
    parameter int RTW = 29
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [2*RTW-1:0] in_rad,
    input  logic             in_neg,
    output logic             out_valid,
    output logic [RTW-1:0]   out_root,
    output logic             out_neg
);
    localparam int SQW = 2 * RTW;

    logic           v_reg    [RTW];
    logic [SQW-1:0] w_reg    [RTW];
    logic [RTW:0]   rem_reg  [RTW];
    logic [RTW-1:0] root_reg [RTW];
    logic           neg_reg  [RTW];

    genvar i;
    generate
        for (i = 0; i < RTW; i++) begin : g_stage
            logic           src_v;
            logic [SQW-1:0] src_w;
            logic [RTW:0]   src_rem;
            logic [RTW-1:0] src_root;
            logic           src_neg;
            logic [RTW+2:0] t;
            logic [RTW+2:0] trial;
            logic           ge;
            logic [RTW+2:0] diff;
            if (i == 0) begin : g_first
                assign src_v    = in_valid;
                assign src_w    = in_rad;
                assign src_rem  = '0;
                assign src_root = '0;
                assign src_neg  = in_neg;
            end else begin : g_next
                assign src_v    = v_reg[i-1];
                assign src_w    = w_reg[i-1];
                assign src_rem  = rem_reg[i-1];
                assign src_root = root_reg[i-1];
                assign src_neg  = neg_reg[i-1];
            end
            assign t     = {src_rem, src_w[SQW-1:SQW-2]};
            assign trial = {1'b0, src_root, 2'b01};
            assign ge    = t >= trial;
            assign diff  = t - trial;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (adv) begin
                    v_reg[i] <= src_v;
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    w_reg[i]    <= {src_w[SQW-3:0], 2'b00};
                    rem_reg[i]  <= ge ? diff[RTW:0] : t[RTW:0];
                    root_reg[i] <= {src_root[RTW-2:0], ge};
                    neg_reg[i]  <= src_neg;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[RTW-1];
    assign out_root  = root_reg[RTW-1];
    assign out_neg   = neg_reg[RTW-1];
endmodule

// File: hdl/rmsd_site_swap_update.sv
`timescale 1ns / 1ps
// top level of the incremental rmsd update after a site swap
// depends on rmsd_pkg, rmsd_div_pipe, rmsd_sqrt_pipe
//
// channel  direction  signals                       request
// s_       in         s_tvalid s_tready s_tdata     one frame pair
// m_       out        m_tvalid m_tready m_tdata     corrected rmsd, status in m_tuser
// cfg_     in         cfg_valid cfg_ready           register index and data
//                     cfg_index cfg_data
//
// one request per cycle sustained while m_ does not stall; each request passes
// stages 1 to 5, divider (2*VW bits), radicand stage, root unit, output register
// reset clears all valid bits and the registers to mode 0, site count 1
// a stall at m_ freezes the whole pipeline in place; s_tready drops with it
// cfg_ready is always high

module rmsd_site_swap_update
    import rmsd_pkg::*;
#(
    parameter int COORD_WIDTH   = CoordWidthDef,
    parameter int ROT_FRAC_BITS = RotFracBitsDef
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // rot_row_x, rot_row_y, rot_row_z, centre_ref_xyz, centre_other_xyz,
    // dropped_ref_xyz, dropped_other_xyz, joined_ref_xyz, joined_other_xyz,
    // old_rmsd, zero pad
    input  logic [583:0]         s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // new_rmsd
    output logic [RmsdWidth-1:0] m_tdata,
    // status
    output logic [0:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CountWidth-1:0]    cfg_data
);
    localparam int CW   = COORD_WIDTH;
    localparam int RF   = ROT_FRAC_BITS;
    localparam int RW   = RF + 2;           // rotation entry
    localparam int DW   = CW + 1;           // p - com_ref
    localparam int XW   = DW + RW;          // single product
    localparam int PW   = XW + 2;           // row sum of three products
    localparam int SHW  = PW - RF;          // after the floor shift
    localparam int VW   = SHW + 2;          // mapped minus target
    localparam int MW   = 2 * VW;           // squared deviation sum
    localparam int OW   = 2 * RmsdWidth;    // old rmsd squared
    localparam int RADW = ((MW + 1 > OW) ? MW + 1 : OW) + 1;
    localparam int RTW  = RADW / 2;
    localparam int SQW  = 2 * RTW;

    // configuration registers
    logic                  unnorm_reg;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] divisor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unnorm_reg <= 1'b0;
            count_reg  <= CountWidth'(1);
        end else if (cfg_valid) begin
            if (cfg_index == CfgUnnormMode) begin
                unnorm_reg <= cfg_data[0];
            end else if (cfg_index == CfgSiteCount) begin
                count_reg <= cfg_data;
            end
        end
    end

    // dividing by one covers unnormalized mode and counts of zero or one
    assign divisor = (unnorm_reg || count_reg <= CountWidth'(1)) ? CountWidth'(1) : count_reg;

    // whole pipeline moves together
    logic m_valid_reg;
    logic adv;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // stage 1: unpack and center the reference coordinates
    logic                 v1_reg;
    logic signed [RW-1:0] rot1_reg  [3][3];
    logic signed [DW-1:0] d1_reg    [2][3];
    logic signed [CW-1:0] coth1_reg [3];
    logic signed [CW-1:0] q1_reg    [2][3];
    logic [RmsdWidth-1:0] old1_reg;

    logic [59:0] rows [3];
    logic [62:0] cref_w, coth_w;
    logic [62:0] pw [2];
    logic [62:0] qw [2];

    assign rows[0] = s_tdata[59:0];
    assign rows[1] = s_tdata[119:60];
    assign rows[2] = s_tdata[179:120];
    assign cref_w  = s_tdata[242:180];
    assign coth_w  = s_tdata[305:243];
    assign pw[0]   = s_tdata[368:306];
    assign qw[0]   = s_tdata[431:369];
    assign pw[1]   = s_tdata[494:432];
    assign qw[1]   = s_tdata[557:495];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    rot1_reg[j][k] <= $signed(rows[j][k*RotStride +: RW]);
                end
                coth1_reg[j] <= $signed(coth_w[j*CW +: CW]);
            end
            for (int s = 0; s < 2; s++) begin
                for (int k = 0; k < 3; k++) begin
                    d1_reg[s][k] <= DW'($signed(pw[s][k*CW +: CW]))
                                  - DW'($signed(cref_w[k*CW +: CW]));
                    q1_reg[s][k] <= $signed(qw[s][k*CW +: CW]);
                end
            end
            old1_reg <= s_tdata[581:558];
        end
    end

    // stage 2: rotation products and old rmsd squared
    logic                 v2_reg;
    logic signed [XW-1:0] prod2_reg [2][3][3];
    logic signed [CW-1:0] coth2_reg [3];
    logic signed [CW-1:0] q2_reg    [2][3];
    logic [OW-1:0]        oldsq2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < 2; s++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        prod2_reg[s][j][k] <= XW'(rot1_reg[j][k]) * XW'(d1_reg[s][k]);
                    end
                    q2_reg[s][j] <= q1_reg[s][j];
                end
            end
            coth2_reg  <= coth1_reg;
            oldsq2_reg <= OW'(old1_reg) * OW'(old1_reg);
        end
    end

    // stage 3: row sums, floor shift, offset to the target
    logic                 v3_reg;
    logic signed [VW-1:0] dev3_reg [2][3];
    logic [OW-1:0]        oldsq3_reg;
    logic signed [PW-1:0] acc      [2][3];
    logic signed [PW-1:0] shifted  [2][3];

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            for (int j = 0; j < 3; j++) begin
                acc[s][j] = PW'(prod2_reg[s][j][0]) + PW'(prod2_reg[s][j][1])
                          + PW'(prod2_reg[s][j][2]);
                shifted[s][j] = acc[s][j] >>> RF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < 2; s++) begin
                for (int j = 0; j < 3; j++) begin
                    dev3_reg[s][j] <= VW'(coth2_reg[j])
                                    + VW'($signed(shifted[s][j][SHW-1:0]))
                                    - VW'(q2_reg[s][j]);
                end
            end
            oldsq3_reg <= oldsq2_reg;
        end
    end

    // stage 4: squares
    logic                 v4_reg;
    logic [MW-1:0]        sq4_reg [2][3];
    logic [OW-1:0]        oldsq4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < 2; s++) begin
                for (int j = 0; j < 3; j++) begin
                    sq4_reg[s][j] <= MW'(dev3_reg[s][j] * dev3_reg[s][j]);
                end
            end
            oldsq4_reg <= oldsq3_reg;
        end
    end

    // stage 5: deviation change as sign and magnitude
    logic                 v5_reg;
    logic [MW-1:0]        mag5_reg;
    logic                 neg5_reg;
    logic [OW-1:0]        oldsq5_reg;
    logic [MW-1:0]        dev_drop, dev_join;
    logic signed [MW:0]   delta;

    always_comb begin
        dev_drop = sq4_reg[0][0] + sq4_reg[0][1] + sq4_reg[0][2];
        dev_join = sq4_reg[1][0] + sq4_reg[1][1] + sq4_reg[1][2];
        delta    = $signed({1'b0, dev_join}) - $signed({1'b0, dev_drop});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg5_reg   <= delta[MW];
            mag5_reg   <= delta[MW] ? MW'(-delta) : delta[MW-1:0];
            oldsq5_reg <= oldsq4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // divider: magnitude over the divisor (the site count, or one), truncating toward zero
    logic              dv_valid;
    logic [MW-1:0]     dv_quo;
    logic [OW:0]       dv_side;

    rmsd_div_pipe #(
        .MW  (MW),
        .DVW (CountWidth),
        .SW  (OW + 1)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v5_reg),
        .in_num    (mag5_reg),
        .in_side   ({neg5_reg, oldsq5_reg}),
        .divisor   (divisor),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // radicand stage
    logic                   vr_reg;
    logic [SQW-1:0]         radmag_reg;
    logic                   radneg_reg;
    logic signed [MW:0]     quo_s;
    logic signed [RADW-1:0] rad;

    always_comb begin
        quo_s = dv_side[OW] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
        rad   = $signed(RADW'(dv_side[OW-1:0])) + RADW'(quo_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr_reg <= 1'b0;
        end else if (adv) begin
            vr_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            radneg_reg <= rad[RADW-1];
            radmag_reg <= SQW'(rad[RADW-2:0]);
        end
    end

    // square root
    logic           sq_valid;
    logic [RTW-1:0] sq_root;
    logic           sq_neg;

    rmsd_sqrt_pipe #(
        .RTW (RTW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vr_reg),
        .in_rad    (radmag_reg),
        .in_neg    (radneg_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_neg   (sq_neg)
    );

    // output register: negative radicand gives zero, large roots saturate
    logic [RmsdWidth-1:0] rmsd_reg;
    logic                 status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            status_reg <= sq_neg;
            if (sq_neg) begin
                rmsd_reg <= '0;
            end else if (sq_root > RTW'(RmsdMax)) begin
                rmsd_reg <= RmsdMax;
            end else begin
                rmsd_reg <= sq_root[RmsdWidth-1:0];
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = rmsd_reg;
    assign m_tuser[0] = status_reg;
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for rmsd_site_swap_update: random and directed frame-pair requests,
// checked against a fixed-point rmsd predictor held in a small scoreboard class
// depends on rmsd_pkg and the rmsd_site_swap_update rtl

module tb_top;
    import rmsd_pkg::*;

    localparam int CW       = CoordWidthDef;
    localparam int FB       = RotFracBitsDef;
    localparam int LIMIT    = 400000;
    localparam int TAILWAIT = 400;

    typedef struct packed {
        logic [RmsdWidth-1:0] rmsd;
        logic                 flag;
    } rmsd_result_t;

    // predictor of the corrected rmsd plus the queue of results still owed
    class rmsd_scoreboard;
        rmsd_result_t owed[$];
        bit           unnorm;
        logic [15:0]  sites;
        int           errors;
        int           checked;
        int           n_neg;
        int           n_sat;

        function void reset_regs();
            unnorm = 1'b0;
            sites  = 16'd1;
        endfunction

        function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [15:0] val);
            if (idx == CfgUnnormMode)
                unnorm = val[0];
            else if (idx == CfgSiteCount)
                sites = val;
        endfunction

        function longint sext(logic [63:0] w, int pos, int wd);
            logic [63:0] raw;
            raw = (w >> pos) << (64 - wd);
            return $signed(raw) >>> (64 - wd);
        endfunction

        function longint site_dev(longint rot[3][3], longint cref[3], longint coth[3],
                                  logic [62:0] pw, logic [62:0] qw);
            longint d[3];
            longint acc;
            longint v;
            longint sum;
            sum = 0;
            for (int k = 0; k < 3; k++)
                d[k] = sext({1'b0, pw}, k * CW, CW) - cref[k];
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += rot[j][k] * d[k];
                v = coth[j] + (acc >>> FB) - sext({1'b0, qw}, j * CW, CW);
                sum += v * v;
            end
            return sum;
        endfunction

        function logic [63:0] root_floor(logic [63:0] n);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // predict the result of one accepted frame-pair request
        function void note_request(logic [583:0] bus);
            longint rot[3][3];
            longint cref[3];
            longint coth[3];
            longint delta;
            longint old;
            longint rad;
            logic [63:0] root;
            rmsd_result_t res;
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                    rot[j][k] = sext({4'd0, bus[j*60 +: 60]}, k * RotStride, FB + 2);
            for (int k = 0; k < 3; k++) begin
                cref[k] = sext({1'b0, bus[180 +: 63]}, k * CW, CW);
                coth[k] = sext({1'b0, bus[243 +: 63]}, k * CW, CW);
            end
            delta = site_dev(rot, cref, coth, bus[432 +: 63], bus[495 +: 63])
                  - site_dev(rot, cref, coth, bus[306 +: 63], bus[369 +: 63]);
            // a site count of zero behaves like one
            if (!unnorm && sites > 1)
                delta = delta / longint'(sites);
            old = longint'(bus[558 +: 24]);
            rad = old * old + delta;
            if (rad < 0) begin
                res.rmsd = '0;
                res.flag = 1'b1;
                n_neg++;
            end else begin
                root = root_floor(rad);
                res.flag = 1'b0;
                if (root > RmsdMax) begin
                    res.rmsd = RmsdMax;
                    n_sat++;
                end else begin
                    res.rmsd = root[RmsdWidth-1:0];
                end
            end
            owed.push_back(res);
        endfunction

        function void check_result(logic [RmsdWidth-1:0] rmsd, logic flag);
            rmsd_result_t exp_res;
            if (owed.size() == 0) begin
                $error("unexpected result new_rmsd=%0d status=%0d", rmsd, flag);
                errors++;
                return;
            end
            exp_res = owed.pop_front();
            checked++;
            if (rmsd !== exp_res.rmsd) begin
                $error("new_rmsd expected %0d actual %0d", exp_res.rmsd, rmsd);
                errors++;
            end
            if (flag !== exp_res.flag) begin
                $error("status expected %0d actual %0d", exp_res.flag, flag);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [583:0]             s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [RmsdWidth-1:0]     m_tdata;
    logic [0:0]               m_tuser;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CountWidth-1:0]    cfg_data;

    rmsd_scoreboard sb;
    int             cycles;
    int             stall_mode;

    rmsd_site_swap_update DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // monitors: requests, results and register writes, all at the rising edge
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // receiver backpressure: patterns change now and then, some with no stalls
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [20:0] rand_coord(int wd);
        logic signed [31:0] r;
        r = $signed($urandom) >>> (32 - wd);
        return r[20:0];
    endfunction

    function automatic logic [62:0] rand_xyz(int wd);
        return {rand_coord(wd), rand_coord(wd), rand_coord(wd)};
    endfunction

    function automatic logic [59:0] rand_row();
        logic [59:0] row;
        logic signed [31:0] r;
        for (int k = 0; k < 3; k++) begin
            r = $signed($urandom) >>> 12;
            if ($urandom_range(0, 3) == 0)
                row[k*20 +: 20] = 20'($urandom);
            else
                row[k*20 +: 20] = 20'(r >>> $urandom_range(1, 6));
        end
        return row;
    endfunction

    function automatic logic [583:0] pack_pair(logic [59:0] rx, logic [59:0] ry,
                                               logic [59:0] rz, logic [62:0] cref,
                                               logic [62:0] coth, logic [62:0] dref,
                                               logic [62:0] doth, logic [62:0] jref,
                                               logic [62:0] joth, logic [23:0] old);
        return {2'b00, old, joth, jref, doth, dref, coth, cref, rz, ry, rx};
    endfunction

    // random frame pair; coordinate scale chosen per request so that
    // deviations range from tiny to full scale
    function automatic logic [583:0] rand_pair();
        int wd;
        logic [23:0] old;
        wd = $urandom_range(2, CW);
        case ($urandom_range(0, 3))
            0: old = 24'($urandom);
            1: old = 24'($urandom_range(0, 4095));
            2: old = '0;
            default: old = 24'($urandom >> $urandom_range(0, 23));
        endcase
        return pack_pair(rand_row(), rand_row(), rand_row(), rand_xyz(wd),
                         rand_xyz(wd), rand_xyz(wd), rand_xyz(wd), rand_xyz(wd),
                         rand_xyz(wd), old);
    endfunction

    task automatic send_pair(logic [583:0] bus);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= bus;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (sb.owed.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && left > 0; i++) begin
                send_pair(rand_pair());
                left--;
            end
            // one pause in a while until all owed results have drained
            if ($urandom_range(0, 19) == 0) begin
                idle_cycles(1);
                wait_drained();
            end else begin
                idle_cycles($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
            end
        end
        idle_cycles(1);
    endtask

    localparam logic [59:0] ROW_X = 60'd1 << FB;
    localparam logic [59:0] ROW_Y = 60'd1 << (FB + 20);
    localparam logic [59:0] ROW_Z = 60'd1 << (FB + 40);
    localparam logic [20:0] CMAX  = 21'h0FFFFF;
    localparam logic [20:0] CMIN  = 21'h100000;

    initial begin
        logic [62:0] far;
        logic [62:0] nearp;
        sb = new();
        sb.reset_regs();
        cycles     = 0;
        stall_mode = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b1;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        far   = {CMAX, CMAX, CMAX};
        nearp = {CMIN, CMIN, CMIN};
        // directed: reset settings, identity and extreme rotations,
        // extreme coordinates, negative radicand and saturated root
        send_pair('0);
        send_pair({584{1'b1}});
        send_pair(pack_pair(ROW_X, ROW_Y, ROW_Z, '0, '0, '0, '0, '0, '0, 24'd1000));
        send_pair(pack_pair(ROW_X, ROW_Y, ROW_Z, '0, '0, '0, '0, far, '0, 24'd5));
        send_pair(pack_pair(ROW_X, ROW_Y, ROW_Z, '0, '0, far, nearp, '0, '0, 24'd0));
        send_pair(pack_pair(ROW_X, ROW_Y, ROW_Z, '0, '0, far, nearp, '0, '0, 24'd7));
        send_pair(pack_pair(ROW_X, ROW_Y, ROW_Z, '0, '0, '0, '0, far, nearp, RmsdMax));
        send_pair(pack_pair(ROW_X, ROW_Y, ROW_Z, '0, '0, '0, '0, '0, '0, RmsdMax));
        send_pair(pack_pair({3{20'h80000}}, {3{20'h80000}}, {3{20'h80000}}, nearp,
                            far, far, nearp, nearp, far, 24'h800000));
        send_pair(pack_pair({3{20'h7FFFF}}, {3{20'h7FFFF}}, {3{20'h7FFFF}}, far,
                            nearp, nearp, far, far, nearp, 24'h000001));
        send_pair(pack_pair({3{20'hFFFFF}}, {3{20'h00001}}, {3{20'hAAAAA}}, far, far,
                            nearp, nearp, far, far, 24'h555555));
        idle_cycles(1);
        wait_drained();

        // unnormalized, with an out-of-range index that must be ignored
        write_reg(CfgUnnormMode, 16'hFFFF);
        write_reg(CfgIndexWidth'(2), 16'h1234);
        send_pair(pack_pair(ROW_X, ROW_Y, ROW_Z, '0, '0, '0, '0, far, nearp, RmsdMax));
        send_pair(pack_pair(ROW_X, ROW_Y, ROW_Z, '0, '0, far, nearp, '0, '0, 24'd3));
        idle_cycles(1);
        random_phase(350);
        wait_drained();

        write_reg(CfgUnnormMode, 16'h0000);
        write_reg(CfgSiteCount, 16'h0000);
        random_phase(300);
        wait_drained();

        write_reg(CfgSiteCount, 16'hFFFF);
        send_pair(pack_pair(ROW_X, ROW_Y, ROW_Z, '0, '0, far, nearp, '0, '0, 24'd0));
        idle_cycles(1);
        random_phase(350);
        wait_drained();

        write_reg(CfgSiteCount, 16'($urandom_range(2, 300)));
        random_phase(350);
        wait_drained();

        write_reg(CfgSiteCount, 16'($urandom));
        write_reg(CfgUnnormMode, 16'h0001);
        random_phase(150);
        wait_drained();

        write_reg(CfgUnnormMode, 16'h0000);
        write_reg(CfgSiteCount, 16'd1);
        random_phase(230);
        wait_drained();
        repeat (TAILWAIT) @(posedge aclk);

        $display("tb_top: %0d results checked, %0d negative radicands, %0d saturated",
                 sb.checked, sb.n_neg, sb.n_sat);
        $display("tb_top: six register settings covered, both modes and site counts 0..65535");
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
